// File: rtl/core/cma_pkg.sv
// ----------------------------------------------------------------------------
// Centered moving average: shared definitions
// Register width and reset value, parameter defaults and state encodings.
// ----------------------------------------------------------------------------
package cma_pkg;

	// Window length register.
	localparam int WL_W = 5;
	localparam logic [WL_W-1:0] WL_RESET = 5'd5;

	// Defaults for the top-level parameters.
	localparam int MAX_HALF_DEF = 15;
	localparam int SAMPLE_BITS_DEF = 24;

	typedef enum logic {
		F_IDLE,
		F_UPDATE
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_START,
		B_DIVIDE,
		B_EMIT,
		B_FETCH,
		B_TRIM
	} back_state_t;

endpackage

// File: rtl/core/cma_div.sv
// ----------------------------------------------------------------------------
// Iterative signed divider
// Divides a two's complement dividend by a positive divisor, one quotient
// bit per cycle, and truncates the quotient toward zero.
// ----------------------------------------------------------------------------
module cma_div #(
	parameter int DIVIDEND_W = 29,
	parameter int DIVISOR_W = 5,
	parameter int QUO_W = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [QUO_W-1:0]      quotient
);

	localparam int STEP_W = $clog2(DIVIDEND_W);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic                  neg_q;
	logic [DIVIDEND_W-1:0] mag_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;

	logic [DIVISOR_W:0]    rem_sh;
	logic [DIVISOR_W:0]    rem_sub;
	logic                  ge;
	logic [DIVIDEND_W-1:0] q_full;

	always_comb begin
		rem_sh  = {rem_q, mag_q[DIVIDEND_W-1]};
		ge      = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
		q_full  = neg_q ? (DIVIDEND_W'(0) - mag_q) : mag_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIVIDEND_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	// The magnitude register shifts out dividend bits and shifts in quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DIVIDEND_W-1];
			mag_q <= dividend[DIVIDEND_W-1] ? (DIVIDEND_W'(0) - dividend) : dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
			mag_q <= {mag_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = q_full[QUO_W-1:0];

endmodule

// File: rtl/core/cma_hist.sv
// ----------------------------------------------------------------------------
// Sample history memory
// Circular buffer with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module cma_hist #(
	parameter int DATA_W = 24,
	parameter int ADDR_W = 5
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_a_en,
	input  logic [ADDR_W-1:0] rd_a_addr,
	output logic [DATA_W-1:0] rd_a_data,
	input  logic              rd_b_en,
	input  logic [ADDR_W-1:0] rd_b_addr,
	output logic [DATA_W-1:0] rd_b_data
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_a_en) begin
			rd_a_data <= mem[rd_a_addr];
		end
		if (rd_b_en) begin
			rd_b_data <= mem[rd_b_addr];
		end
	end

endmodule

// File: rtl/core/cma_front.sv
// ----------------------------------------------------------------------------
// Centered moving average: front end
// Accepts samples, writes the history, keeps the running window sum and
// the sample count, and hands one job per sample to the back end.
// ----------------------------------------------------------------------------
module cma_front #(
	parameter int MAX_HALF = cma_pkg::MAX_HALF_DEF,
	parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEF,
	parameter int HALF_W = $clog2(MAX_HALF + 1),
	parameter int CNT_W = HALF_W + 1,
	parameter int SUM_W = SAMPLE_BITS + CNT_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wen,
	input  logic [cma_pkg::WL_W-1:0] cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [SAMPLE_BITS-1:0]   in_sample,
	input  logic                     in_last,
	input  logic                     slot_full,
	output logic                     push,
	output logic [SUM_W-1:0]         job_sum,
	output logic [CNT_W-1:0]         job_rc,
	output logic [CNT_W-1:0]         job_ptr,
	output logic [HALF_W-1:0]        job_h,
	output logic                     job_last,
	output logic                     mem_wr_en,
	output logic [CNT_W-1:0]         mem_wr_addr,
	output logic [SAMPLE_BITS-1:0]   mem_wr_data,
	output logic                     mem_rd_en,
	output logic [CNT_W-1:0]         mem_rd_addr,
	input  logic [SAMPLE_BITS-1:0]   mem_rd_data
);

	localparam logic [CNT_W-1:0] HIST_DEPTH = CNT_W'(2 * MAX_HALF + 1);

	cma_pkg::front_state_t state_q, state_d;

	logic [cma_pkg::WL_W-1:0] wl_q;
	logic [CNT_W-1:0]         rc_q;
	logic [SUM_W-1:0]         sum_q;
	logic [CNT_W-1:0]         ptr_q;
	logic [SAMPLE_BITS-1:0]   smp_q;
	logic                     last_q;

	logic [HALF_W-1:0] half;
	logic              accept;
	logic              drop;
	logic [SUM_W-1:0]  sum_new;
	logic [CNT_W-1:0]  rc_new;

	always_comb begin
		if (32'(wl_q >> 1) > 32'(MAX_HALF)) begin
			half = HALF_W'(MAX_HALF);
		end else begin
			half = HALF_W'(wl_q >> 1);
		end
	end

	// Once the signal fills the window, the sample 2h behind the newest one
	// leaves the window as the new one enters.
	always_comb begin
		drop    = rc_q >= {half, 1'b1};
		sum_new = sum_q
			+ {{(SUM_W - SAMPLE_BITS){smp_q[SAMPLE_BITS-1]}}, smp_q}
			- (drop ? {{(SUM_W - SAMPLE_BITS){mem_rd_data[SAMPLE_BITS-1]}}, mem_rd_data}
				: SUM_W'(0));
		rc_new  = (rc_q < HIST_DEPTH) ? rc_q + 1'b1 : rc_q;
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		push     = 1'b0;
		case (state_q)
			cma_pkg::F_IDLE: begin
				in_ready = !slot_full;
				if (in_valid && !slot_full) begin
					state_d = cma_pkg::F_UPDATE;
				end
			end
			cma_pkg::F_UPDATE: begin
				push    = 1'b1;
				state_d = cma_pkg::F_IDLE;
			end
			default: begin
				state_d = cma_pkg::F_IDLE;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cma_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q  <= cma_pkg::WL_RESET;
			rc_q  <= '0;
			sum_q <= '0;
			ptr_q <= '0;
		end else begin
			if (cfg_wen) begin
				wl_q  <= cfg_wdata;
				rc_q  <= '0;
				sum_q <= '0;
			end else if (push) begin
				rc_q  <= last_q ? '0 : rc_new;
				sum_q <= last_q ? '0 : sum_new;
			end
			if (accept) begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q  <= in_sample;
			last_q <= in_last;
		end
	end

	assign mem_wr_en   = accept;
	assign mem_wr_addr = ptr_q + 1'b1;
	assign mem_wr_data = in_sample;
	assign mem_rd_en   = accept;
	assign mem_rd_addr = ptr_q - {half, 1'b0};

	assign job_sum  = sum_new;
	assign job_rc   = rc_new;
	assign job_ptr  = ptr_q;
	assign job_h    = half;
	assign job_last = last_q;

endmodule

// File: rtl/core/cma_back.sv
// ----------------------------------------------------------------------------
// Centered moving average: back end
// Turns each job into zero, one or a flush of several averages, divides
// every window sum by its sample count and holds the result word.
// ----------------------------------------------------------------------------
module cma_back #(
	parameter int MAX_HALF = cma_pkg::MAX_HALF_DEF,
	parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEF,
	parameter int HALF_W = $clog2(MAX_HALF + 1),
	parameter int CNT_W = HALF_W + 1,
	parameter int SUM_W = SAMPLE_BITS + CNT_W
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   job_valid,
	output logic                   job_pop,
	input  logic [SUM_W-1:0]       job_sum,
	input  logic [CNT_W-1:0]       job_rc,
	input  logic [CNT_W-1:0]       job_ptr,
	input  logic [HALF_W-1:0]      job_h,
	input  logic                   job_last,
	output logic                   mem_rd_en,
	output logic [CNT_W-1:0]       mem_rd_addr,
	input  logic [SAMPLE_BITS-1:0] mem_rd_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [SAMPLE_BITS-1:0] out_average,
	output logic                   out_last
);

	cma_pkg::back_state_t state_q, state_d;

	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [HALF_W-1:0] d_q;
	logic [HALF_W-1:0] h_q;
	logic [CNT_W-1:0]  rc_q;
	logic [CNT_W-1:0]  ptr_q;
	logic              last_q;

	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_avg_q;
	logic                   out_last_q;

	logic                   div_start;
	logic                   div_done;
	logic [SAMPLE_BITS-1:0] div_quo;

	logic [CNT_W-1:0]  two_h1;
	logic [CNT_W-1:0]  rc_m1;
	logic [CNT_W-1:0]  dh;
	logic              wanted;
	logic              out_load;
	logic              finished;
	logic              shrink;

	always_comb begin
		two_h1   = {job_h, 1'b1};
		rc_m1    = job_rc - 1'b1;
		wanted   = job_last || (job_rc > CNT_W'(job_h));
		dh       = CNT_W'(d_q) + CNT_W'(h_q);
		out_load = (state_q == cma_pkg::B_EMIT) && (!out_valid_q || out_ready);
		// A non-final job gives one word; a flush runs down to the last position.
		finished = !last_q || (d_q == '0);
		// The window end drops back by one only where it is not already clipped
		// by the end of the signal.
		shrink   = dh < rc_q;
	end

	always_comb begin
		state_d   = state_q;
		job_pop   = 1'b0;
		div_start = 1'b0;
		mem_rd_en = 1'b0;
		case (state_q)
			cma_pkg::B_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					if (wanted) begin
						state_d = cma_pkg::B_START;
					end
				end
			end
			cma_pkg::B_START: begin
				div_start = 1'b1;
				state_d   = cma_pkg::B_DIVIDE;
			end
			cma_pkg::B_DIVIDE: begin
				if (div_done) begin
					state_d = cma_pkg::B_EMIT;
				end
			end
			cma_pkg::B_EMIT: begin
				if (out_load) begin
					if (finished) begin
						state_d = cma_pkg::B_IDLE;
					end else if (shrink) begin
						state_d = cma_pkg::B_FETCH;
					end else begin
						state_d = cma_pkg::B_START;
					end
				end
			end
			cma_pkg::B_FETCH: begin
				mem_rd_en = 1'b1;
				state_d   = cma_pkg::B_TRIM;
			end
			cma_pkg::B_TRIM: begin
				state_d = cma_pkg::B_START;
			end
			default: begin
				state_d = cma_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cma_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cma_pkg::B_IDLE: begin
				sum_q  <= job_sum;
				h_q    <= job_h;
				rc_q   <= job_rc;
				ptr_q  <= job_ptr;
				last_q <= job_last;
				cnt_q  <= (job_rc < two_h1) ? job_rc : two_h1;
				if (job_last && (rc_m1 < CNT_W'(job_h))) begin
					d_q <= rc_m1[HALF_W-1:0];
				end else begin
					d_q <= job_h;
				end
			end
			cma_pkg::B_EMIT: begin
				if (out_load && !finished && !shrink) begin
					d_q <= d_q - 1'b1;
				end
			end
			cma_pkg::B_TRIM: begin
				sum_q <= sum_q
					- {{(SUM_W - SAMPLE_BITS){mem_rd_data[SAMPLE_BITS-1]}}, mem_rd_data};
				cnt_q <= cnt_q - 1'b1;
				d_q   <= d_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign mem_rd_addr = ptr_q - dh;

	cma_div #(
		.DIVIDEND_W (SUM_W),
		.DIVISOR_W  (CNT_W),
		.QUO_W      (SAMPLE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_avg_q  <= div_quo;
			out_last_q <= last_q && (d_q == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign out_average = out_avg_q;
	assign out_last    = out_last_q;

endmodule

// File: rtl/core/centered_moving_average.sv
// ----------------------------------------------------------------------------
// Centered moving average filter
// Averages each sample with its neighbors within half a window length.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the s_ group: s_tdata holds one signed sample, s_tlast
// marks the final sample of a signal. Averages leave on the m_ group, and
// m_tlast marks the final average of the signal. cfg_wen writes the window
// length from cfg_wdata; a write also restarts the current signal. A write
// must be made only while the block is idle; the block does not enforce it.
// With half-width h, the average for a position leaves once the sample h
// places later has arrived. The word marked last flushes the remaining up
// to h+1 averages, the window shrinking at both ends of the signal.
// Sequence: the front end accepts a word in F_IDLE and pushes its job in
// F_UPDATE, taking no new word in F_UPDATE, and the back end pops the job
// from the queue. Each average then comes from the bit-serial divider, and
// a flush that shrinks the window first reads the history in B_FETCH and
// B_TRIM. A one-entry job queue lets the front take the next word while
// the back end divides. A stalled m_tready holds the result word and, once
// the queue is full, s_tready drops. Reset sets the window length to 5 and
// starts a new signal; the history memory needs no clearing.
// ----------------------------------------------------------------------------
module centered_moving_average #(
	parameter int MAX_HALF = cma_pkg::MAX_HALF_DEF,
	parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [cma_pkg::WL_W-1:0]            cfg_wdata,  // window_length
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,    // sample
	input  logic                                s_tlast,    // is_last
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,    // average
	output logic                                m_tlast     // last_out
);

	localparam int HALF_W = $clog2(MAX_HALF + 1);
	localparam int CNT_W = HALF_W + 1;
	localparam int SUM_W = SAMPLE_BITS + CNT_W;
	localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

	logic                   front_push;
	logic [SUM_W-1:0]       front_sum;
	logic [CNT_W-1:0]       front_rc;
	logic [CNT_W-1:0]       front_ptr;
	logic [HALF_W-1:0]      front_h;
	logic                   front_last;

	logic                   slot_valid_q;
	logic [SUM_W-1:0]       slot_sum_q;
	logic [CNT_W-1:0]       slot_rc_q;
	logic [CNT_W-1:0]       slot_ptr_q;
	logic [HALF_W-1:0]      slot_h_q;
	logic                   slot_last_q;
	logic                   back_pop;

	logic                   wr_en;
	logic [CNT_W-1:0]       wr_addr;
	logic [SAMPLE_BITS-1:0] wr_data;
	logic                   fr_rd_en;
	logic [CNT_W-1:0]       fr_rd_addr;
	logic [SAMPLE_BITS-1:0] fr_rd_data;
	logic                   bk_rd_en;
	logic [CNT_W-1:0]       bk_rd_addr;
	logic [SAMPLE_BITS-1:0] bk_rd_data;

	logic [SAMPLE_BITS-1:0] avg;

	cma_front #(
		.MAX_HALF    (MAX_HALF),
		.SAMPLE_BITS (SAMPLE_BITS),
		.HALF_W      (HALF_W),
		.CNT_W       (CNT_W),
		.SUM_W       (SUM_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_sample   (s_tdata[SAMPLE_BITS-1:0]),
		.in_last     (s_tlast),
		.slot_full   (slot_valid_q),
		.push        (front_push),
		.job_sum     (front_sum),
		.job_rc      (front_rc),
		.job_ptr     (front_ptr),
		.job_h       (front_h),
		.job_last    (front_last),
		.mem_wr_en   (wr_en),
		.mem_wr_addr (wr_addr),
		.mem_wr_data (wr_data),
		.mem_rd_en   (fr_rd_en),
		.mem_rd_addr (fr_rd_addr),
		.mem_rd_data (fr_rd_data)
	);

	// One-entry job queue. The front end only takes a word while it is empty,
	// so it never runs more than one sample ahead of the job being flushed
	// and cannot overwrite history that the back end still reads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= 1'b0;
		end else if (front_push) begin
			slot_valid_q <= 1'b1;
		end else if (back_pop) begin
			slot_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (front_push) begin
			slot_sum_q  <= front_sum;
			slot_rc_q   <= front_rc;
			slot_ptr_q  <= front_ptr;
			slot_h_q    <= front_h;
			slot_last_q <= front_last;
		end
	end

	cma_hist #(
		.DATA_W (SAMPLE_BITS),
		.ADDR_W (CNT_W)
	) u_hist (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_a_en   (fr_rd_en),
		.rd_a_addr (fr_rd_addr),
		.rd_a_data (fr_rd_data),
		.rd_b_en   (bk_rd_en),
		.rd_b_addr (bk_rd_addr),
		.rd_b_data (bk_rd_data)
	);

	cma_back #(
		.MAX_HALF    (MAX_HALF),
		.SAMPLE_BITS (SAMPLE_BITS),
		.HALF_W      (HALF_W),
		.CNT_W       (CNT_W),
		.SUM_W       (SUM_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (slot_valid_q),
		.job_pop     (back_pop),
		.job_sum     (slot_sum_q),
		.job_rc      (slot_rc_q),
		.job_ptr     (slot_ptr_q),
		.job_h       (slot_h_q),
		.job_last    (slot_last_q),
		.mem_rd_en   (bk_rd_en),
		.mem_rd_addr (bk_rd_addr),
		.mem_rd_data (bk_rd_data),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_average (avg),
		.out_last    (m_tlast)
	);

	assign m_tdata = TDATA_W'(avg);

`ifndef ASSERT_OFF
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		front_push |-> !slot_valid_q)
		else $error("job pushed into a full queue");

	a_job_has_samples: assert property (@(posedge clk) disable iff (!arst_n)
		slot_valid_q |-> (slot_rc_q != '0))
		else $error("queued job with zero sample count");

	a_front_two_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (!s_tready && front_push))
		else $error("front end did not complete the accepted word");
`endif

endmodule

// File: sim/cma_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Centered moving average: checker
// Watches the sample, average and register channels and keeps its own copy of
// the filter state. It predicts every average and compares each word leaving
// the block against the oldest prediction.
// ----------------------------------------------------------------------------
module cma_checker #(
	parameter int MAX_HALF = cma_pkg::MAX_HALF_DEF,
	parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [cma_pkg::WL_W-1:0]            cfg_wdata,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
	input  logic                                s_tlast,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,
	input  logic                                m_tlast,
	output int                                  errors,
	output int                                  pending
);

	localparam int DEPTH = 2 * MAX_HALF + 1;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] average;
		logic                   last_out;
	} avg_word_t;

	logic signed [SAMPLE_BITS-1:0] hist [DEPTH];
	logic [cma_pkg::WL_W-1:0]      win_len;
	int                            seen;
	avg_word_t                     expected_avgs [$];
	int                            mismatch_total = 0;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_total++;
	endtask

	// Mean of the in-range samples around the position d places behind the newest.
	function automatic logic [SAMPLE_BITS-1:0] window_mean(input int d, input int h,
			input int rc);
		int     lo;
		int     hi;
		longint acc;
		longint q;
		lo = (d > h) ? d - h : 0;
		hi = d + h;
		if (hi > rc - 1)
			hi = rc - 1;
		acc = 0;
		for (int k = lo; k <= hi; k++)
			acc += hist[k];
		q = acc / longint'(hi - lo + 1);
		return q[SAMPLE_BITS-1:0];
	endfunction

	task automatic take_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic lst);
		int        h;
		int        d;
		avg_word_t w;
		h = int'(win_len >> 1);
		if (h > MAX_HALF)
			h = MAX_HALF;
		for (int k = DEPTH - 1; k > 0; k--)
			hist[k] = hist[k-1];
		hist[0] = smp;
		if (seen < DEPTH)
			seen++;
		if (lst) begin
			// The last word flushes every position still waiting, oldest first.
			d = (h < seen - 1) ? h : seen - 1;
			for (int e = d; e >= 0; e--) begin
				w.average = window_mean(e, h, seen);
				w.last_out = (e == 0);
				expected_avgs.push_back(w);
			end
			seen = 0;
		end else if (seen > h) begin
			w.average = window_mean(h, h, seen);
			w.last_out = 1'b0;
			expected_avgs.push_back(w);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		avg_word_t w;
		if (!arst_n) begin
			win_len = cma_pkg::WL_RESET;
			seen = 0;
			for (int k = 0; k < DEPTH; k++)
				hist[k] = '0;
			expected_avgs.delete();
		end else begin
			// An average leaving now always belongs to an earlier sample.
			if (m_tvalid && m_tready) begin
				if (expected_avgs.size() == 0) begin
					report_mismatch($sformatf("unexpected word %0h last %0b",
						m_tdata, m_tlast));
				end else begin
					w = expected_avgs.pop_front();
					if (m_tdata[SAMPLE_BITS-1:0] !== w.average)
						report_mismatch($sformatf("average %0h, predicted %0h",
							m_tdata[SAMPLE_BITS-1:0], w.average));
					if (m_tlast !== w.last_out)
						report_mismatch($sformatf("last flag %0b, predicted %0b",
							m_tlast, w.last_out));
				end
			end
			if (cfg_wen) begin
				win_len = cfg_wdata;
				seen = 0;
			end
			if (s_tvalid && s_tready)
				take_sample(s_tdata[SAMPLE_BITS-1:0], s_tlast);
		end
		errors <= mismatch_total;
		pending <= expected_avgs.size();
	end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Centered moving average: testbench
// Drives signals of samples through the filter under several window lengths,
// with random gaps on both channels, a long output stall and register writes
// between signals. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

	localparam int MH = cma_pkg::MAX_HALF_DEF;
	localparam int SB = cma_pkg::SAMPLE_BITS_DEF;
	localparam int DW = ((SB + 7) / 8) * 8;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES = 600;
	localparam int SETTLE_CYCLES = 100;
	localparam int PHASE_ITEMS = 100;
	localparam logic [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_wen = 1'b0;
	logic [cma_pkg::WL_W-1:0] cfg_wdata = '0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [DW-1:0]            s_tdata = '0;
	logic                     s_tlast = 1'b0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [DW-1:0]            m_tdata;
	logic                     m_tlast;
	int                       errors;
	int                       pending;

	int send_idle = 31;
	int recv_idle = 86;
	int stall_reqs = 0;
	int stall_served = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	centered_moving_average #(
		.MAX_HALF(MH),
		.SAMPLE_BITS(SB)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	cma_checker #(
		.MAX_HALF(MH),
		.SAMPLE_BITS(SB)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.errors(errors),
		.pending(pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver: random back-pressure, or a long hold-off when one is requested.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_reqs != stall_served) begin
			stall_served <= stall_served + 1;
			stall_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [SB-1:0] pick_sample();
		logic [SB-1:0] v;
		case ($urandom_range(9))
			0: v = SMAX;
			1: v = SMIN;
			2, 3: v = SB'($urandom_range(200) - 100);
			default: v = SB'($urandom);
		endcase
		return v;
	endfunction

	// Offers one word after a random gap and returns at the edge that takes it.
	task automatic send_sample(input logic [SB-1:0] smp, input logic lst);
		while ($urandom_range(99) < send_idle) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= DW'(smp);
		s_tlast <= lst;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Stops offering and waits until every predicted average has left.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		// A word that makes no average may still be in the front end.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic restart_with_window(input logic [cma_pkg::WL_W-1:0] wl);
		drain();
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= wl;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	initial begin
		int   n;
		int   len;
		bit   broken;
		bit   held;
		logic [cma_pkg::WL_W-1:0] wl;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: a one-word signal at the reset window length.
		send_sample(SMAX, 1'b1);
		// A window length of zero behaves as a length of one.
		restart_with_window(5'd0);
		send_sample(SMIN, 1'b0);
		send_sample(SMAX, 1'b1);
		// A signal shorter than the half-width comes out all at once.
		restart_with_window(5'd31);
		send_sample(SMAX, 1'b0);
		send_sample(SMAX, 1'b0);
		send_sample(SMIN, 1'b1);
		// Even length: the window still spans 2*h+1 samples.
		restart_with_window(5'd4);
		send_sample(SMAX, 1'b0);
		send_sample(SMAX, 1'b0);
		send_sample(SMIN, 1'b0);
		send_sample(SMIN, 1'b0);
		send_sample(SMAX, 1'b1);
		// A register write in the middle of a signal drops what was received.
		restart_with_window(5'd3);
		send_sample(SMIN, 1'b0);
		send_sample(24'h000001, 1'b0);
		restart_with_window(5'd3);
		send_sample(24'h123456, 1'b1);
		restart_with_window(5'd1);
		send_sample(SMAX, 1'b0);
		send_sample(SMIN, 1'b1);
		restart_with_window(5'd2);
		send_sample(24'hFFFFFF, 1'b0);
		send_sample(24'h000000, 1'b0);
		send_sample(24'hAAAAAA, 1'b0);
		send_sample(24'h555555, 1'b1);

		held = 1'b0;
		broken = 1'b0;
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle = 31;
					recv_idle = 86;
				end
				1: begin
					send_idle = 86;
					recv_idle = 31;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			n = 0;
			while (n < PHASE_ITEMS) begin
				if (broken || $urandom_range(9) < 6) begin
					case ($urandom_range(7))
						0: wl = 5'd1;
						1: wl = 5'd31;
						default: wl = 5'($urandom_range(31, 1));
					endcase
					restart_with_window(wl);
				end
				case ($urandom_range(9))
					0: len = 1;
					1: len = $urandom_range(70, 32);
					default: len = $urandom_range(20, 2);
				endcase
				// Hold the receiver off while a long signal keeps coming.
				if (ph == 2 && !held && n >= 20) begin
					held = 1'b1;
					len = 48;
					stall_reqs = stall_reqs + 1;
				end
				broken = ($urandom_range(9) == 0);
				for (int i = 0; i < len; i++)
					send_sample(pick_sample(), !broken && (i == len - 1));
				n += len;
			end
		end

		drain();
		if (errors == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/cma_pkg.sv
rtl/core/cma_div.sv
rtl/core/cma_hist.sv
rtl/core/cma_front.sv
rtl/core/cma_back.sv
rtl/core/centered_moving_average.sv
sim/cma_checker.sv
sim/testbench.sv
